// ===== rtl/gdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gdp_pkg: shared types and constants for dead-path propagation
// Table sizes, field widths, command and status codes, controller states and
// the control and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gdp_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 128;
    localparam int MaxPins  = 16;

    localparam int NW       = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
    localparam int EW       = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
    localparam int PW       = (MaxPins > 1) ? $clog2(MaxPins) : 1;
    localparam int PinSlots = MaxNodes * MaxPins;
    localparam int SW       = (PinSlots > 1) ? $clog2(PinSlots) : 1;
    localparam int NCW      = $clog2(MaxNodes + 1);
    localparam int ECW      = $clog2(MaxEdges + 1);
    localparam int LCW      = $clog2(2 * MaxEdges + 1);
    localparam int FCW      = $clog2(MaxPins + 1);

    // Fixed field widths of the stream items.
    localparam int IdW      = 32;
    localparam int PinW     = 8;
    localparam int MaskW    = 16;
    localparam int CntInW   = 5;
    localparam int QiW      = 7;
    localparam int InDataW  = 144;
    localparam int OutDataW = 24;

    // Stored words.
    localparam int NodeWordW = IdW + FCW + MaskW;
    localparam int EdgeWordW = 2 * IdW + 2 * PinW + 1;

    localparam logic [2:0] CmdClear     = 3'd0;
    localparam logic [2:0] CmdAddNode   = 3'd1;
    localparam logic [2:0] CmdAddEdge   = 3'd2;
    localparam logic [2:0] CmdCompute   = 3'd3;
    localparam logic [2:0] CmdQueryNode = 3'd4;
    localparam logic [2:0] CmdQueryEdge = 3'd5;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StRange = 2'd2;

    typedef enum logic [21:0] {
        ST_IDLE     = 22'h000001,
        ST_CLR      = 22'h000002,
        ST_RES_RD   = 22'h000004,
        ST_RES_LD   = 22'h000008,
        ST_SCAN     = 22'h000010,
        ST_CHK      = 22'h000020,
        ST_INC_RD   = 22'h000040,
        ST_INC_WR   = 22'h000080,
        ST_FED_RD   = 22'h000100,
        ST_FED_WR   = 22'h000200,
        ST_SEED_RD  = 22'h000400,
        ST_SEED_CHK = 22'h000800,
        ST_POP      = 22'h001000,
        ST_POP_WT   = 22'h002000,
        ST_FLOW_LD  = 22'h004000,
        ST_DEC_RD   = 22'h008000,
        ST_DEC_WR   = 22'h010000,
        ST_FDEC_RD  = 22'h020000,
        ST_FDEC_WR  = 22'h040000,
        ST_KILL_RD  = 22'h080000,
        ST_KILL_CHK = 22'h100000,
        ST_DONE     = 22'h200000
    } t_state;

    // Up to two feeding relations per edge.
    typedef struct packed {
        logic [1:0]    count;
        logic [NW-1:0] dst0;
        logic [PW-1:0] pin0;
        logic [NW-1:0] src0;
        logic [NW-1:0] dst1;
        logic [PW-1:0] pin1;
        logic [NW-1:0] src1;
    } t_flow;

    typedef struct packed {
        t_state st;
        logic   accept;
        logic   edge_step;
        logic   k_step;
    } t_cmd;

    typedef struct packed {
        logic       out_busy;
        logic [2:0] code;
        logic       empty;
        logic       clr_last;
        logic       edge_last;
        logic       scan_done;
        logic       new_flow_nz;
        logic       k_last;
        logic       pin_zero;
        logic       pin_one;
        logic       fed_zero;
        logic       fed_one;
        logic       dst_dead;
        logic       kill_last;
        logic       sp_zero;
        logic       flow_nz;
    } t_stat;

endpackage

// ===== rtl/graph_dead_path_propagation.sv =====
// ----------------------------------------------------------------------------
// graph_dead_path_propagation: dead-path propagation over a loaded graph
// Loads, compute and queries are sequenced by gdp_ctrl over the tables in gdp_dp.
// ----------------------------------------------------------------------------
// Latency: clear, add, query and unused commands answer 1 cycle after acceptance.
// Compute clears the pin-count and fed-pin memories, then for every edge scans the
// nodes to resolve both ends and counts each fed pin, seeds the worklist with the
// muted edges, and per popped edge releases its fed pins and scans for killed nodes.
// One word is in flight at a time; the node scan, one node read per cycle for
// every edge, sets the compute time. Reset empties both tables and clears all dead flags.
module graph_dead_path_propagation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // s_tdata from bit 0: node_id, pin_count, pin_in_mask, end_a_node, end_a_pin,
    // end_b_node, end_b_pin, muted, query_index, zero fill
    input  logic [143:0]   s_tdata,
    // s_tuser: command
    input  logic [2:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // m_tdata from bit 0: status, dead_flag, dead_node_total, dead_edge_total,
    // zero fill
    output logic [23:0]    m_tdata
);
    import gdp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    gdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_tvalid),
        .o_s_ready(s_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    gdp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_s_data (s_tdata),
        .i_s_user (s_tuser),
        .o_m_valid(m_tvalid),
        .i_m_ready(m_tready),
        .o_m_data (m_tdata)
    );

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (w_cmd.st == ST_IDLE))
        else $error("input ready outside the idle state");

    a_simple_answers_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tuser != CmdCompute) |=> m_tvalid)
        else $error("non-compute command did not answer in one cycle");

    a_range_has_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1:0] == StRange) |-> !m_tdata[2])
        else $error("out-of-range query reported a dead flag");

endmodule

// ===== rtl/gdp_ram.sv =====
// ----------------------------------------------------------------------------
// gdp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                       i_wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                       o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdp_ctrl: sequencing state machine
// Accepts commands and walks the compute phases: table clear, edge resolve,
// pin counting, seeding and worklist propagation.
// ----------------------------------------------------------------------------
module gdp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  gdp_pkg::t_stat i_stat,
    output gdp_pkg::t_cmd  o_cmd
);
    import gdp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_ready;
    logic   w_accept;
    logic   w_edge_step;
    logic   w_k_step;

    assign w_ready  = (r_state == ST_IDLE) && (!i_stat.out_busy);
    assign w_accept = w_ready && i_s_valid;

    always_comb begin
        n_state     = r_state;
        w_edge_step = 1'b0;
        w_k_step    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_stat.code == CmdCompute && !i_stat.empty) begin
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                if (i_stat.clr_last) begin
                    n_state = ST_RES_RD;
                end
            end
            ST_RES_RD: n_state = ST_RES_LD;
            ST_RES_LD: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.new_flow_nz) begin
                    n_state = ST_INC_RD;
                end else begin
                    w_edge_step = 1'b1;
                    n_state     = i_stat.edge_last ? ST_SEED_RD : ST_RES_RD;
                end
            end
            ST_INC_RD: n_state = ST_INC_WR;
            ST_INC_WR, ST_FED_WR: begin
                if (r_state == ST_INC_WR && i_stat.pin_zero) begin
                    n_state = ST_FED_RD;
                end else if (i_stat.k_last) begin
                    w_edge_step = 1'b1;
                    n_state     = i_stat.edge_last ? ST_SEED_RD : ST_RES_RD;
                end else begin
                    w_k_step = 1'b1;
                    n_state  = ST_INC_RD;
                end
            end
            ST_FED_RD: n_state = ST_FED_WR;
            ST_SEED_RD: n_state = ST_SEED_CHK;
            ST_SEED_CHK: begin
                w_edge_step = 1'b1;
                n_state     = i_stat.edge_last ? ST_POP : ST_SEED_RD;
            end
            ST_POP: n_state = i_stat.sp_zero ? ST_DONE : ST_POP_WT;
            ST_POP_WT: n_state = ST_FLOW_LD;
            ST_FLOW_LD: n_state = i_stat.flow_nz ? ST_DEC_RD : ST_POP;
            ST_DEC_RD: n_state = ST_DEC_WR;
            ST_DEC_WR, ST_FDEC_WR, ST_KILL_CHK: begin
                if (r_state == ST_DEC_WR && !i_stat.pin_zero && i_stat.pin_one) begin
                    n_state = ST_FDEC_RD;
                end else if (r_state == ST_FDEC_WR && !i_stat.fed_zero
                             && i_stat.fed_one && !i_stat.dst_dead) begin
                    n_state = ST_KILL_RD;
                end else if (r_state == ST_KILL_CHK && !i_stat.kill_last) begin
                    n_state = ST_KILL_RD;
                end else if (i_stat.k_last) begin
                    n_state = ST_POP;
                end else begin
                    w_k_step = 1'b1;
                    n_state  = ST_DEC_RD;
                end
            end
            ST_FDEC_RD: n_state = ST_FDEC_WR;
            ST_KILL_RD: n_state = ST_KILL_CHK;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready       = w_ready;
    assign o_cmd.st        = r_state;
    assign o_cmd.accept    = w_accept;
    assign o_cmd.edge_step = w_edge_step;
    assign o_cmd.k_step    = w_k_step;

endmodule

// ===== rtl/gdp_dp.sv =====
// ----------------------------------------------------------------------------
// gdp_dp: tables, counters and result register
// Holds the node, edge, flow, pin-count, fed-pin and worklist memories, the
// dead flags, and carries out the step that the controller selects.
// ----------------------------------------------------------------------------
module gdp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gdp_pkg::t_cmd                  i_cmd,
    output gdp_pkg::t_stat                 o_stat,
    input  logic [gdp_pkg::InDataW-1:0]    i_s_data,
    input  logic [2:0]                     i_s_user,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic [gdp_pkg::OutDataW-1:0]   o_m_data
);
    import gdp_pkg::*;

    // Input fields.
    logic [IdW-1:0]    w_node_id;
    logic [CntInW-1:0] w_pin_count;
    logic [MaskW-1:0]  w_mask;
    logic [IdW-1:0]    w_a_node;
    logic [PinW-1:0]   w_a_pin;
    logic [IdW-1:0]    w_b_node;
    logic [PinW-1:0]   w_b_pin;
    logic              w_muted;
    logic [QiW-1:0]    w_qi;

    assign w_node_id   = i_s_data[31:0];
    assign w_pin_count = i_s_data[36:32];
    assign w_mask      = i_s_data[52:37];
    assign w_a_node    = i_s_data[84:53];
    assign w_a_pin     = i_s_data[92:85];
    assign w_b_node    = i_s_data[124:93];
    assign w_b_pin     = i_s_data[132:125];
    assign w_muted     = i_s_data[133];
    assign w_qi        = i_s_data[140:134];

    // Control registers.
    logic [NCW-1:0]      r_nodes;
    logic [ECW-1:0]      r_edges;
    logic [MaxNodes-1:0] r_node_dead;
    logic [MaxEdges-1:0] r_edge_dead;
    logic [NCW-1:0]      r_dn;
    logic [ECW-1:0]      r_de;
    logic                r_ovalid;
    logic [SW-1:0]       r_i;
    logic [EW-1:0]       r_e;
    logic [NCW-1:0]      r_j;
    logic                r_pend;
    logic                r_a_found;
    logic                r_b_found;
    logic                r_k;
    logic [EW-1:0]       r_o;
    logic [ECW-1:0]      r_sp;

    // Payload registers.
    logic [NW-1:0]    r_pend_idx;
    logic [IdW-1:0]   r_a_id;
    logic [IdW-1:0]   r_b_id;
    logic [PinW-1:0]  r_pa;
    logic [PinW-1:0]  r_pb;
    logic [NW-1:0]    r_a_idx;
    logic [NW-1:0]    r_b_idx;
    logic [FCW-1:0]   r_a_pc;
    logic [FCW-1:0]   r_b_pc;
    logic [MaskW-1:0] r_a_mask;
    logic [MaskW-1:0] r_b_mask;
    t_flow            r_flow;
    logic [NW-1:0]    r_n;
    logic [1:0]       r_status;
    logic             r_flag;
    logic [6:0]       r_out_dn;
    logic [7:0]       r_out_de;

    // Memory ports.
    logic [NodeWordW-1:0]   w_node_wdata;
    logic [NodeWordW-1:0]   w_node_rd;
    logic                   w_node_we;
    logic [EdgeWordW-1:0]   w_edge_wdata;
    logic [EdgeWordW-1:0]   w_edge_rd;
    logic                   w_edge_we;
    logic [$bits(t_flow)-1:0] w_flow_rd_bits;
    t_flow                  w_flow_rd;
    t_flow                  w_new_flow;
    logic                   w_flow_we;
    logic [EW-1:0]          w_flow_raddr;
    logic                   w_stk_we;
    logic [EW-1:0]          w_stk_wdata;
    logic [EW-1:0]          w_stk_rd;
    logic [ECW-1:0]         w_sp_dec;
    logic                   w_pin_we;
    logic [SW-1:0]          w_pin_waddr;
    logic [LCW-1:0]         w_pin_wdata;
    logic [LCW-1:0]         w_pin_rd;
    logic [SW-1:0]          w_idx;
    logic                   w_fed_we;
    logic [NW-1:0]          w_fed_waddr;
    logic [FCW-1:0]         w_fed_wdata;
    logic [FCW-1:0]         w_fed_rd;

    // Decode and compare.
    logic           w_acc;
    logic           w_node_full;
    logic           w_edge_full;
    logic           w_qn_ok;
    logic           w_qe_ok;
    logic [FCW-1:0] w_pc_clamped;
    logic           w_edge_last;
    logic           w_kill_last;
    logic           w_issue;
    logic           w_a_hit;
    logic           w_b_hit;
    logic           w_valid_edge;
    logic           w_a_in;
    logic           w_b_in;
    logic [NW-1:0]  w_cur_dst;
    logic [PW-1:0]  w_cur_pin;
    logic           w_kill_hit;
    logic           w_seed;
    logic           w_kill_start;
    logic           w_clr_fed;
    logic           w_respond_now;

    assign w_acc       = i_cmd.accept;
    assign w_node_full = (r_nodes == NCW'(MaxNodes));
    assign w_edge_full = (r_edges == ECW'(MaxEdges));
    assign w_qn_ok     = (16'(w_qi) < 16'(r_nodes));
    assign w_qe_ok     = (16'(w_qi) < 16'(r_edges));
    assign w_pc_clamped = (32'(w_pin_count) > 32'(MaxPins)) ? FCW'(MaxPins)
                                                            : FCW'(w_pin_count);
    assign w_edge_last = ((ECW'(r_e) + ECW'(1)) == r_edges);
    assign w_kill_last = ((ECW'(r_o) + ECW'(1)) == r_edges);
    assign w_respond_now = !(i_s_user == CmdCompute
                             && r_nodes != '0 && r_edges != '0);

    // Node scan: one read issued per cycle, the match checked in the next cycle.
    assign w_issue = (i_cmd.st == ST_SCAN) && (r_j < r_nodes);
    assign w_a_hit = r_pend && (w_node_rd[IdW-1:0] == r_a_id);
    assign w_b_hit = r_pend && (w_node_rd[IdW-1:0] == r_b_id);

    // An edge feeds only when both ends resolve and both pins are in range.
    assign w_valid_edge = r_a_found && r_b_found
        && !r_pa[PinW-1] && ((PinW + FCW)'(r_pa) < (PinW + FCW)'(r_a_pc))
        && !r_pb[PinW-1] && ((PinW + FCW)'(r_pb) < (PinW + FCW)'(r_b_pc));
    assign w_a_in = w_valid_edge && (r_pa[PinW-2:4] == '0) && r_a_mask[r_pa[3:0]];
    assign w_b_in = w_valid_edge && (r_pb[PinW-2:4] == '0) && r_b_mask[r_pb[3:0]];

    always_comb begin
        w_new_flow       = '0;
        w_new_flow.count = {1'b0, w_a_in} + {1'b0, w_b_in};
        if (w_a_in) begin
            w_new_flow.dst0 = r_a_idx;
            w_new_flow.pin0 = PW'(r_pa);
            w_new_flow.src0 = r_b_idx;
            w_new_flow.dst1 = r_b_idx;
            w_new_flow.pin1 = PW'(r_pb);
            w_new_flow.src1 = r_a_idx;
        end else begin
            w_new_flow.dst0 = r_b_idx;
            w_new_flow.pin0 = PW'(r_pb);
            w_new_flow.src0 = r_a_idx;
        end
    end

    assign w_cur_dst = r_k ? r_flow.dst1 : r_flow.dst0;
    assign w_cur_pin = r_k ? r_flow.pin1 : r_flow.pin0;
    assign w_idx     = SW'(w_cur_dst) * SW'(MaxPins) + SW'(w_cur_pin);

    assign w_flow_rd  = t_flow'(w_flow_rd_bits);
    assign w_kill_hit = (i_cmd.st == ST_KILL_CHK) && !r_edge_dead[r_o]
        && ((w_flow_rd.count != 2'd0 && w_flow_rd.src0 == r_n)
            || (w_flow_rd.count == 2'd2 && w_flow_rd.src1 == r_n));
    assign w_seed = (i_cmd.st == ST_SEED_CHK) && w_edge_rd[EdgeWordW-1];
    assign w_kill_start = (i_cmd.st == ST_FDEC_WR) && (w_fed_rd == FCW'(1))
                          && !r_node_dead[w_cur_dst];
    assign w_clr_fed = (i_cmd.st == ST_CLR)
                       && ((SW + 1)'(r_i) < (SW + 1)'(MaxNodes));

    // Memory controls.
    assign w_node_we    = w_acc && (i_s_user == CmdAddNode) && !w_node_full;
    assign w_node_wdata = {w_mask, w_pc_clamped, w_node_id};
    assign w_edge_we    = w_acc && (i_s_user == CmdAddEdge) && !w_edge_full;
    assign w_edge_wdata = {w_muted, w_b_pin, w_a_pin, w_b_node, w_a_node};
    assign w_flow_we    = (i_cmd.st == ST_CHK);
    assign w_flow_raddr = (i_cmd.st == ST_POP_WT) ? w_stk_rd : r_o;
    assign w_stk_we     = w_seed || w_kill_hit;
    assign w_stk_wdata  = (i_cmd.st == ST_SEED_CHK) ? r_e : r_o;
    assign w_sp_dec     = r_sp - ECW'(1);

    assign w_pin_we    = (i_cmd.st == ST_CLR) || (i_cmd.st == ST_INC_WR)
                         || ((i_cmd.st == ST_DEC_WR) && (w_pin_rd != '0));
    assign w_pin_waddr = (i_cmd.st == ST_CLR) ? r_i : w_idx;
    assign w_pin_wdata = (i_cmd.st == ST_CLR) ? '0
                       : (i_cmd.st == ST_INC_WR) ? (w_pin_rd + LCW'(1))
                       : (w_pin_rd - LCW'(1));

    assign w_fed_we    = w_clr_fed || (i_cmd.st == ST_FED_WR)
                         || ((i_cmd.st == ST_FDEC_WR) && (w_fed_rd != '0));
    assign w_fed_waddr = (i_cmd.st == ST_CLR) ? r_i[NW-1:0] : w_cur_dst;
    assign w_fed_wdata = (i_cmd.st == ST_CLR) ? '0
                       : (i_cmd.st == ST_FED_WR) ? (w_fed_rd + FCW'(1))
                       : (w_fed_rd - FCW'(1));

    gdp_ram #(.Width(NodeWordW), .Depth(MaxNodes)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_node_we),
        .i_waddr(r_nodes[NW-1:0]),
        .i_wdata(w_node_wdata),
        .i_raddr(r_j[NW-1:0]),
        .o_rdata(w_node_rd)
    );

    gdp_ram #(.Width(EdgeWordW), .Depth(MaxEdges)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (w_edge_we),
        .i_waddr(r_edges[EW-1:0]),
        .i_wdata(w_edge_wdata),
        .i_raddr(r_e),
        .o_rdata(w_edge_rd)
    );

    gdp_ram #(.Width($bits(t_flow)), .Depth(MaxEdges)) u_flow_ram (
        .i_clk  (i_clk),
        .i_we   (w_flow_we),
        .i_waddr(r_e),
        .i_wdata(w_new_flow),
        .i_raddr(w_flow_raddr),
        .o_rdata(w_flow_rd_bits)
    );

    gdp_ram #(.Width(EW), .Depth(MaxEdges)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (w_stk_we),
        .i_waddr(r_sp[EW-1:0]),
        .i_wdata(w_stk_wdata),
        .i_raddr(w_sp_dec[EW-1:0]),
        .o_rdata(w_stk_rd)
    );

    gdp_ram #(.Width(LCW), .Depth(PinSlots)) u_pin_ram (
        .i_clk  (i_clk),
        .i_we   (w_pin_we),
        .i_waddr(w_pin_waddr),
        .i_wdata(w_pin_wdata),
        .i_raddr(w_idx),
        .o_rdata(w_pin_rd)
    );

    gdp_ram #(.Width(FCW), .Depth(MaxNodes)) u_fed_ram (
        .i_clk  (i_clk),
        .i_we   (w_fed_we),
        .i_waddr(w_fed_waddr),
        .i_wdata(w_fed_wdata),
        .i_raddr(w_cur_dst),
        .o_rdata(w_fed_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes     <= '0;
            r_edges     <= '0;
            r_node_dead <= '0;
            r_edge_dead <= '0;
            r_dn        <= '0;
            r_de        <= '0;
            r_ovalid    <= 1'b0;
            r_i         <= '0;
            r_e         <= '0;
            r_j         <= '0;
            r_pend      <= 1'b0;
            r_a_found   <= 1'b0;
            r_b_found   <= 1'b0;
            r_k         <= 1'b0;
            r_o         <= '0;
            r_sp        <= '0;
        end else begin
            // A word is only accepted once the previous answer has left.
            if (i_cmd.st == ST_DONE) begin
                r_ovalid <= 1'b1;
            end else if (w_acc) begin
                r_ovalid <= w_respond_now;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.st)
                ST_IDLE: begin
                    if (w_acc) begin
                        priority case (i_s_user)
                            CmdClear: begin
                                r_nodes     <= '0;
                                r_edges     <= '0;
                                r_node_dead <= '0;
                                r_edge_dead <= '0;
                            end
                            CmdAddNode: begin
                                if (!w_node_full) begin
                                    r_node_dead[r_nodes[NW-1:0]] <= 1'b0;
                                    r_nodes <= r_nodes + NCW'(1);
                                end
                            end
                            CmdAddEdge: begin
                                if (!w_edge_full) begin
                                    r_edge_dead[r_edges[EW-1:0]] <= 1'b0;
                                    r_edges <= r_edges + ECW'(1);
                                end
                            end
                            CmdCompute: begin
                                r_node_dead <= '0;
                                r_edge_dead <= '0;
                                r_dn        <= '0;
                                r_de        <= '0;
                                r_i         <= '0;
                                r_e         <= '0;
                                r_sp        <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLR: r_i <= r_i + SW'(1);
                ST_RES_LD: begin
                    r_j       <= '0;
                    r_pend    <= 1'b0;
                    r_a_found <= 1'b0;
                    r_b_found <= 1'b0;
                end
                ST_SCAN: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_j <= r_j + NCW'(1);
                    end
                    if (w_a_hit) begin
                        r_a_found <= 1'b1;
                    end
                    if (w_b_hit) begin
                        r_b_found <= 1'b1;
                    end
                end
                ST_CHK, ST_FLOW_LD: r_k <= 1'b0;
                ST_SEED_CHK: begin
                    if (w_seed) begin
                        r_edge_dead[r_e] <= 1'b1;
                        r_de <= r_de + ECW'(1);
                        r_sp <= r_sp + ECW'(1);
                    end
                end
                ST_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= w_sp_dec;
                    end
                end
                ST_FDEC_WR: begin
                    if (w_kill_start) begin
                        r_node_dead[w_cur_dst] <= 1'b1;
                        r_dn <= r_dn + NCW'(1);
                        r_o  <= '0;
                    end
                end
                ST_KILL_CHK: begin
                    if (w_kill_hit) begin
                        r_edge_dead[r_o] <= 1'b1;
                        r_de <= r_de + ECW'(1);
                        r_sp <= r_sp + ECW'(1);
                    end
                    r_o <= r_o + EW'(1);
                end
                default: ;
            endcase
            if (i_cmd.edge_step) begin
                r_e <= w_edge_last ? '0 : (r_e + EW'(1));
            end
            if (i_cmd.k_step) begin
                r_k <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.st)
            ST_IDLE: begin
                if (w_acc) begin
                    r_out_dn <= '0;
                    r_out_de <= '0;
                    priority case (i_s_user)
                        CmdAddNode: begin
                            r_status <= w_node_full ? StFull : StOk;
                            r_flag   <= 1'b0;
                        end
                        CmdAddEdge: begin
                            r_status <= w_edge_full ? StFull : StOk;
                            r_flag   <= 1'b0;
                        end
                        CmdQueryNode: begin
                            r_status <= w_qn_ok ? StOk : StRange;
                            r_flag   <= w_qn_ok && r_node_dead[NW'(w_qi)];
                        end
                        CmdQueryEdge: begin
                            r_status <= w_qe_ok ? StOk : StRange;
                            r_flag   <= w_qe_ok && r_edge_dead[EW'(w_qi)];
                        end
                        default: begin
                            r_status <= StOk;
                            r_flag   <= 1'b0;
                        end
                    endcase
                end
            end
            ST_RES_LD: begin
                r_a_id <= w_edge_rd[IdW-1:0];
                r_b_id <= w_edge_rd[2*IdW-1:IdW];
                r_pa   <= w_edge_rd[2*IdW+PinW-1:2*IdW];
                r_pb   <= w_edge_rd[2*IdW+2*PinW-1:2*IdW+PinW];
            end
            ST_SCAN: begin
                r_pend_idx <= r_j[NW-1:0];
                // Scan runs upward, so the last matching node wins.
                if (w_a_hit) begin
                    r_a_idx  <= r_pend_idx;
                    r_a_pc   <= w_node_rd[IdW+FCW-1:IdW];
                    r_a_mask <= w_node_rd[NodeWordW-1:IdW+FCW];
                end
                if (w_b_hit) begin
                    r_b_idx  <= r_pend_idx;
                    r_b_pc   <= w_node_rd[IdW+FCW-1:IdW];
                    r_b_mask <= w_node_rd[NodeWordW-1:IdW+FCW];
                end
            end
            ST_CHK: r_flow <= w_new_flow;
            ST_FLOW_LD: r_flow <= w_flow_rd;
            ST_FDEC_WR: r_n <= w_cur_dst;
            ST_DONE: begin
                r_status <= StOk;
                r_flag   <= 1'b0;
                r_out_dn <= 7'(r_dn);
                r_out_de <= 8'(r_de);
            end
            default: ;
        endcase
    end

    assign o_stat.out_busy    = r_ovalid && !i_m_ready;
    assign o_stat.code        = i_s_user;
    assign o_stat.empty       = (r_nodes == '0) || (r_edges == '0);
    assign o_stat.clr_last    = (r_i == SW'(PinSlots - 1));
    assign o_stat.edge_last   = w_edge_last;
    assign o_stat.scan_done   = !w_issue && !r_pend;
    assign o_stat.new_flow_nz = (w_new_flow.count != 2'd0);
    assign o_stat.k_last      = r_k || (r_flow.count == 2'd1);
    assign o_stat.pin_zero    = (w_pin_rd == '0);
    assign o_stat.pin_one     = (w_pin_rd == LCW'(1));
    assign o_stat.fed_zero    = (w_fed_rd == '0);
    assign o_stat.fed_one     = (w_fed_rd == FCW'(1));
    assign o_stat.dst_dead    = r_node_dead[w_cur_dst];
    assign o_stat.kill_last   = w_kill_last;
    assign o_stat.sp_zero     = (r_sp == '0);
    assign o_stat.flow_nz     = (w_flow_rd.count != 2'd0);

    assign o_m_valid = r_ovalid;
    assign o_m_data  = {6'd0, r_out_de, r_out_dn, r_flag, r_status};

endmodule

// ===== tb/graph_dead_path_propagation_tb.sv =====
// ----------------------------------------------------------------------------
// graph_dead_path_propagation_tb: self-checking bench for dead-path propagation
// Builds random dataflow graphs, runs compute and queries every node and edge.
// A behavioral predictor computes each expected answer word, and a monitor
// compares every output word with the oldest expectation.
// ----------------------------------------------------------------------------
module graph_dead_path_propagation_tb;
    import gdp_pkg::*;

    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [7:0] de;
        logic [6:0] dn;
        logic       flag;
        logic [1:0] status;
    } t_answer;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] nid;
        logic [4:0]  pc;
        logic [15:0] mask;
        logic [31:0] aid;
        logic [7:0]  apin;
        logic [31:0] bid;
        logic [7:0]  bpin;
        logic        muted;
        logic [6:0]  qi;
    } t_word;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // fields from bit 0: node_id, pin_count, pin_in_mask, end_a_node, end_a_pin,
    // end_b_node, end_b_pin, muted, query_index, zero fill
    logic [143:0] s_tdata;
    // fields: command
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // fields from bit 0: status, dead_flag, dead_node_total, dead_edge_total
    logic [23:0]  m_tdata;

    graph_dead_path_propagation u_dut (.*);

    // Predictor state.
    logic [31:0] g_id [MaxNodes];
    int          g_pc [MaxNodes];
    logic [15:0] g_mask [MaxNodes];
    int          g_nodes;
    logic [31:0] g_aid [MaxEdges];
    logic [31:0] g_bid [MaxEdges];
    logic [7:0]  g_apin [MaxEdges];
    logic [7:0]  g_bpin [MaxEdges];
    logic        g_mute [MaxEdges];
    int          g_edges;
    bit          g_ndead [MaxNodes];
    bit          g_edead [MaxEdges];

    t_word   pending_words[$];
    t_answer expected_answers[$];
    int      errors, words_sent, answers_seen, computes_seen, idle_mode;
    int      stall_cycles;
    bit      stim_done;

    function automatic int lookup_node(logic [31:0] id);
        for (int i = g_nodes - 1; i >= 0; i--)
            if (g_id[i] == id) return i;
        return -1;
    endfunction

    task automatic propagate_dead();
        int fcnt [MaxEdges];
        int fdst [MaxEdges][2];
        int fpin [MaxEdges][2];
        int fsrc [MaxEdges][2];
        int live [MaxNodes * MaxPins];
        int fed [MaxNodes];
        int stack[$];
        int a, b, pa, pb, e, n, ix;
        for (int i = 0; i < MaxNodes; i++) g_ndead[i] = 0;
        for (int i = 0; i < MaxEdges; i++) g_edead[i] = 0;
        if (g_nodes == 0 || g_edges == 0) return;
        foreach (live[i]) live[i] = 0;
        foreach (fed[i]) fed[i] = 0;
        for (int i = 0; i < g_edges; i++) begin
            fcnt[i] = 0;
            a = lookup_node(g_aid[i]);
            b = lookup_node(g_bid[i]);
            pa = g_apin[i];
            pb = g_bpin[i];
            if (a < 0 || b < 0) continue;
            if (pa >= 128 || pa >= g_pc[a]) continue;
            if (pb >= 128 || pb >= g_pc[b]) continue;
            if (pa < 16 && g_mask[a][pa]) begin
                fdst[i][fcnt[i]] = a; fpin[i][fcnt[i]] = pa; fsrc[i][fcnt[i]] = b;
                fcnt[i]++;
            end
            if (pb < 16 && g_mask[b][pb]) begin
                fdst[i][fcnt[i]] = b; fpin[i][fcnt[i]] = pb; fsrc[i][fcnt[i]] = a;
                fcnt[i]++;
            end
            for (int k = 0; k < fcnt[i]; k++) begin
                ix = fdst[i][k] * MaxPins + fpin[i][k];
                if (live[ix] == 0) fed[fdst[i][k]]++;
                live[ix]++;
            end
        end
        for (int i = 0; i < g_edges; i++)
            if (g_mute[i]) begin
                g_edead[i] = 1;
                stack.insert(stack.size(), i);
            end
        while (stack.size() > 0) begin
            e = stack[stack.size() - 1];
            stack.delete(stack.size() - 1);
            for (int k = 0; k < fcnt[e]; k++) begin
                n = fdst[e][k];
                ix = n * MaxPins + fpin[e][k];
                if (live[ix] == 0) continue;
                live[ix]--;
                if (live[ix] != 0) continue;
                if (fed[n] == 0) continue;
                fed[n]--;
                if (fed[n] != 0 || g_ndead[n]) continue;
                g_ndead[n] = 1;
                for (int o = 0; o < g_edges; o++)
                    for (int j = 0; j < fcnt[o]; j++)
                        if (fsrc[o][j] == n && !g_edead[o]) begin
                            g_edead[o] = 1;
                            stack.insert(stack.size(), o);
                            break;
                        end
            end
        end
    endtask

    task automatic predict_answer(t_word w);
        t_answer r;
        r = '0;
        case (w.cmd)
            CmdClear: begin
                g_nodes = 0;
                g_edges = 0;
                for (int i = 0; i < MaxNodes; i++) g_ndead[i] = 0;
                for (int i = 0; i < MaxEdges; i++) g_edead[i] = 0;
            end
            CmdAddNode: begin
                if (g_nodes >= MaxNodes) r.status = StFull;
                else begin
                    g_id[g_nodes] = w.nid;
                    g_pc[g_nodes] = (w.pc > MaxPins) ? MaxPins : w.pc;
                    g_mask[g_nodes] = w.mask;
                    g_ndead[g_nodes] = 0;
                    g_nodes++;
                end
            end
            CmdAddEdge: begin
                if (g_edges >= MaxEdges) r.status = StFull;
                else begin
                    g_aid[g_edges] = w.aid;
                    g_bid[g_edges] = w.bid;
                    g_apin[g_edges] = w.apin;
                    g_bpin[g_edges] = w.bpin;
                    g_mute[g_edges] = w.muted;
                    g_edead[g_edges] = 0;
                    g_edges++;
                end
            end
            CmdCompute: begin
                propagate_dead();
                for (int i = 0; i < g_nodes; i++) r.dn += g_ndead[i];
                for (int i = 0; i < g_edges; i++) r.de += g_edead[i];
            end
            CmdQueryNode: begin
                if (w.qi >= g_nodes) r.status = StRange;
                else r.flag = g_ndead[w.qi];
            end
            CmdQueryEdge: begin
                if (w.qi >= g_edges) r.status = StRange;
                else r.flag = g_edead[w.qi];
            end
            default: ;
        endcase
        expected_answers.insert(expected_answers.size(), r);
    endtask

    function automatic t_word blank_word(logic [2:0] cmd);
        t_word w;
        w.cmd = cmd;
        w.nid = $urandom; w.pc = $urandom; w.mask = $urandom;
        w.aid = $urandom; w.apin = $urandom; w.bid = $urandom;
        w.bpin = $urandom; w.muted = $urandom; w.qi = $urandom;
        return w;
    endfunction

    task automatic queue_word(t_word w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // Ids come from a small pool so that edges usually resolve.
    function automatic logic [31:0] pool_id(int base, int span);
        if ($urandom_range(0, 15) == 0) return $urandom;
        return 32'(base + $urandom_range(0, span - 1));
    endfunction

    task automatic add_graph(int nn, int ne, int mute_pct);
        t_word w;
        int base;
        base = $urandom_range(0, 3) == 0 ? -5 : $urandom_range(0, 1) ? 0 : 32'h7fff_fff0;
        w = blank_word(CmdClear);
        queue_word(w);
        for (int i = 0; i < nn; i++) begin
            w = blank_word(CmdAddNode);
            w.nid = pool_id(base, nn);
            w.pc = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 6);
            queue_word(w);
        end
        for (int i = 0; i < ne; i++) begin
            w = blank_word(CmdAddEdge);
            w.aid = pool_id(base, nn);
            w.bid = pool_id(base, nn);
            w.apin = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 5);
            w.bpin = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 5);
            w.muted = $urandom_range(0, 99) < mute_pct;
            queue_word(w);
        end
        queue_word(blank_word(CmdCompute));
        for (int i = 0; i < nn + 1; i++) begin
            w = blank_word(CmdQueryNode); w.qi = i; queue_word(w);
        end
        for (int i = 0; i < ne + 1; i++) begin
            w = blank_word(CmdQueryEdge); w.qi = i; queue_word(w);
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) words_sent++;
            if (pending_words.size() > 0
                && !(idle_mode == 0 && $urandom_range(0, 99) < 33)
                && !(idle_mode == 1 && $urandom_range(0, 99) < 60)) begin
                t_word w;
                w = pending_words.pop_front();
                predict_answer(w);
                s_tvalid <= 1;
                s_tuser <= w.cmd;
                s_tdata <= {3'd0, w.qi, w.muted, w.bpin, w.bid, w.apin, w.aid,
                            w.mask, w.pc, w.nid};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                t_answer got, exp;
                got = m_tdata[17:0];
                answers_seen++;
                if (got.dn != 0) computes_seen++;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end else begin
                    exp = expected_answers.pop_front();
                    if (got.status != exp.status)
                        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                    if (got.flag != exp.flag)
                        $display("%0t: dead_flag exp %0d got %0d", $time, exp.flag, got.flag);
                    if (got.dn != exp.dn)
                        $display("%0t: dead nodes exp %0d got %0d", $time, exp.dn, got.dn);
                    if (got.de != exp.de)
                        $display("%0t: dead edges exp %0d got %0d", $time, exp.de, got.de);
                    if (got != exp) errors++;
                end
            end
            m_tready <= !((idle_mode == 0 && $urandom_range(0, 99) < 60)
                          || (idle_mode == 1 && $urandom_range(0, 99) < 33));
        end
    end

    // Watchdog: fails the run when the stall counter passes its limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 400000) begin
            $display("graph_dead_path_propagation regression: fail");
            $finish;
        end
    end

    initial begin
        t_word w;
        errors = 0; words_sent = 0; answers_seen = 0; computes_seen = 0;
        g_nodes = 0; g_edges = 0; idle_mode = 0;
        for (int i = 0; i < MaxNodes; i++) g_ndead[i] = 0;
        for (int i = 0; i < MaxEdges; i++) g_edead[i] = 0;
        i_rst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty graph, unused codes, extremes, both ends input, full tables.
        queue_word(blank_word(CmdCompute));
        queue_word(blank_word(3'd6));
        queue_word(blank_word(3'd7));
        w = blank_word(CmdQueryNode); w.qi = 0; queue_word(w);
        w = blank_word(CmdAddNode); w.nid = 32'h8000_0000; w.pc = 5'h1f; w.mask = 16'hffff;
        queue_word(w);
        w = blank_word(CmdAddNode); w.nid = 32'h7fff_ffff; w.pc = 16; w.mask = 16'hffff;
        queue_word(w);
        w = blank_word(CmdAddEdge); w.aid = 32'h8000_0000; w.bid = 32'h7fff_ffff;
        w.apin = 15; w.bpin = 0; w.muted = 1; queue_word(w);
        w = blank_word(CmdAddEdge); w.aid = 32'h7fff_ffff; w.bid = 32'h8000_0000;
        w.apin = 8'h80; w.bpin = 8'h7f; w.muted = 1; queue_word(w);
        w = blank_word(CmdAddEdge); w.aid = 32'h1234; w.bid = 32'h7fff_ffff;
        w.apin = 0; w.bpin = 3; w.muted = 0; queue_word(w);
        queue_word(blank_word(CmdCompute));
        for (int i = 0; i < 4; i++) begin
            w = blank_word(CmdQueryEdge); w.qi = i; queue_word(w);
        end
        w = blank_word(CmdAddNode); queue_word(w);
        w = blank_word(CmdQueryNode); w.qi = 2; queue_word(w);
        w = blank_word(CmdQueryNode); w.qi = 127; queue_word(w);
        add_graph(MaxNodes, MaxEdges, 20);
        queue_word(blank_word(CmdAddNode));
        queue_word(blank_word(CmdAddEdge));

        // Random graphs across the three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            int target;
            target = words_sent + 160;
            while (words_sent < target) begin
                if ($urandom_range(0, 9) == 0)
                    queue_word(blank_word(3'($urandom_range(0, 7))));
                else
                    add_graph($urandom_range(1, 10), $urandom_range(1, 14),
                              $urandom_range(5, 40));
                wait (pending_words.size() == 0);
                @(posedge i_clk);
            end
            wait (pending_words.size() == 0 && expected_answers.size() == 0 && !s_tvalid);
            idle_mode = ph + 1;
        end
        repeat (50) @(posedge i_clk);
        $display("Sent %0d words, checked %0d answers, %0d computes with dead nodes.",
                 words_sent, answers_seen, computes_seen);
        if (errors == 0 && expected_answers.size() == 0)
            $display("graph_dead_path_propagation regression: pass");
        else
            $display("graph_dead_path_propagation regression: fail");
        $finish;
    end
endmodule
